// ===== hw/rtl/blcr_pkg.sv =====
// Shared types and defaults for the line rasterizer with color ramp.
package blcr_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam logic [7:0] PEN_RADIUS_RESET = 8'd1;

    typedef enum logic [1:0] {
        MODE_VERTICAL   = 2'd0,
        MODE_HORIZONTAL = 2'd1,
        MODE_BRESENHAM  = 2'd2
    } line_mode_t;

    typedef enum logic {
        KIND_START = 1'b0,
        KIND_STEP  = 1'b1
    } item_kind_t;

    // Control part of the line state; step directions are kept as sign bits
    typedef struct packed {
        logic       active;
        line_mode_t mode;
        logic       major_is_x;
        logic       x_neg;
        logic       y_neg;
    } line_ctrl_t;

endpackage

// ===== hw/rtl/bresenham_line_color_ramp.sv =====
// Top level of the line rasterizer with color ramp and pen radius pass-through.
//
// Input stream s_*: one transfer per item. s_tuser is the item kind (start or
// step); s_tdata carries the endpoints and start color. A start item sets up a
// new line, dropping any line in progress, and yields its first point. Each
// step item yields the next point; m_tlast marks the final point. A step with
// no line in progress yields a result with m_tuser (point valid) low and all
// other fields zero. The config channel cfg_* writes the pen radius, which is
// sent along with every point.
//
// Throughput: one item per cycle unless the receiver stalls. Each input transfer
// writes its result into the output register; setup or advance of the line runs
// in the same cycle against the registered line state.
// When the receiver stalls, the output register holds its result and s_tready
// drops; s_tready stays high while the output register is empty or drains.
// Reset clears the line state (no line in progress), empties the output
// register and sets the pen radius to 1. cfg_ready is always high.
module bresenham_line_color_ramp
    import blcr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int DW = COORD_BITS + 3,
    localparam int IN_W = ((4 * COORD_BITS + 32 + 7) / 8) * 8,
    localparam int OUT_W = ((2 * COORD_BITS + 40 + 7) / 8) * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // x_start, y_start, x_end, y_end, start_color
    input  logic             s_tuser,   // kind
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // point_x, point_y, point_color, point_radius
    output logic             m_tuser,   // point_valid
    output logic             m_tlast,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [7:0]       cfg_data
);

    localparam int CB = COORD_BITS;

    logic signed [CB-1:0] in_x_start, in_y_start, in_x_end, in_y_end;
    logic        [31:0]   in_color;
    logic                 accept;

    line_ctrl_t           ctrl_reg, ctrl_next, setup_ctrl;
    logic signed [CB-1:0] cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic signed [DW-1:0] decision_reg, decision_next;
    logic signed [DW-1:0] inc_straight_reg, inc_straight_next;
    logic signed [DW-1:0] inc_diagonal_reg, inc_diagonal_next;
    logic        [CB-1:0] steps_reg, steps_next;
    logic        [31:0]   color_reg, color_next;
    logic        [7:0]    pen_radius_reg;

    logic signed [CB-1:0] setup_x, setup_y;
    logic signed [DW-1:0] setup_decision, setup_inc_s, setup_inc_d;
    logic        [CB-1:0] setup_steps;
    logic signed [CB-1:0] step_x, step_y;
    logic signed [DW-1:0] step_decision;
    logic        [CB-1:0] step_steps;

    logic                 out_valid_reg, out_valid_next;
    logic                 res_pv;
    logic signed [CB-1:0] res_x, res_y;
    logic        [31:0]   res_color;
    logic        [7:0]    res_radius;
    logic                 res_last;
    logic                 out_pv_reg;
    logic signed [CB-1:0] out_x_reg, out_y_reg;
    logic        [31:0]   out_color_reg;
    logic        [7:0]    out_radius_reg;
    logic                 out_last_reg;

    assign in_x_start = s_tdata[CB-1:0];
    assign in_y_start = s_tdata[2*CB-1:CB];
    assign in_x_end   = s_tdata[3*CB-1:2*CB];
    assign in_y_end   = s_tdata[4*CB-1:3*CB];
    assign in_color   = s_tdata[4*CB+31:4*CB];

    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    blcr_setup #(.COORD_BITS(COORD_BITS)) u_setup (
        .x_start      (in_x_start),
        .y_start      (in_y_start),
        .x_end        (in_x_end),
        .y_end        (in_y_end),
        .ctrl         (setup_ctrl),
        .first_x      (setup_x),
        .first_y      (setup_y),
        .decision     (setup_decision),
        .inc_straight (setup_inc_s),
        .inc_diagonal (setup_inc_d),
        .steps        (setup_steps)
    );

    blcr_step #(.COORD_BITS(COORD_BITS)) u_step (
        .ctrl          (ctrl_reg),
        .cur_x         (cur_x_reg),
        .cur_y         (cur_y_reg),
        .decision      (decision_reg),
        .inc_straight  (inc_straight_reg),
        .inc_diagonal  (inc_diagonal_reg),
        .steps         (steps_reg),
        .next_x        (step_x),
        .next_y        (step_y),
        .next_decision (step_decision),
        .next_steps    (step_steps)
    );

    always_comb
    begin
        ctrl_next         = ctrl_reg;
        cur_x_next        = cur_x_reg;
        cur_y_next        = cur_y_reg;
        decision_next     = decision_reg;
        inc_straight_next = inc_straight_reg;
        inc_diagonal_next = inc_diagonal_reg;
        steps_next        = steps_reg;
        color_next        = color_reg;
        res_pv            = 1'b0;
        res_x             = '0;
        res_y             = '0;
        res_color         = '0;
        res_radius        = '0;
        res_last          = 1'b0;
        if (item_kind_t'(s_tuser) == KIND_START || ctrl_reg.active)
        begin
            if (item_kind_t'(s_tuser) == KIND_START)
            begin
                ctrl_next         = setup_ctrl;
                cur_x_next        = setup_x;
                cur_y_next        = setup_y;
                decision_next     = setup_decision;
                inc_straight_next = setup_inc_s;
                inc_diagonal_next = setup_inc_d;
                steps_next        = setup_steps;
                res_color         = in_color;
            end
            else
            begin
                cur_x_next    = step_x;
                cur_y_next    = step_y;
                decision_next = step_decision;
                steps_next    = step_steps;
                res_color     = color_reg;
            end
            // emit the point, close the line on its final point, advance the ramp except on horizontal lines
            res_pv           = 1'b1;
            res_x            = cur_x_next;
            res_y            = cur_y_next;
            res_radius       = pen_radius_reg;
            res_last         = (steps_next == '0);
            ctrl_next.active = (steps_next != '0);
            color_next       = (ctrl_next.mode == MODE_HORIZONTAL) ? res_color
                                                                   : res_color + 32'd1;
        end
        out_valid_next = accept ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg         <= '{active: 1'b0, mode: MODE_VERTICAL, major_is_x: 1'b0,
                                  x_neg: 1'b0, y_neg: 1'b0};
            cur_x_reg        <= '0;
            cur_y_reg        <= '0;
            decision_reg     <= '0;
            inc_straight_reg <= '0;
            inc_diagonal_reg <= '0;
            steps_reg        <= '0;
            color_reg        <= '0;
            out_valid_reg    <= 1'b0;
            pen_radius_reg   <= PEN_RADIUS_RESET;
        end
        else
        begin
            if (accept)
            begin
                ctrl_reg         <= ctrl_next;
                cur_x_reg        <= cur_x_next;
                cur_y_reg        <= cur_y_next;
                decision_reg     <= decision_next;
                inc_straight_reg <= inc_straight_next;
                inc_diagonal_reg <= inc_diagonal_next;
                steps_reg        <= steps_next;
                color_reg        <= color_next;
            end
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                pen_radius_reg <= cfg_data;
            end
        end
    end

    // result payload, held while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_pv_reg     <= res_pv;
            out_x_reg      <= res_x;
            out_y_reg      <= res_y;
            out_color_reg  <= res_color;
            out_radius_reg <= res_radius;
            out_last_reg   <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_radius_reg, out_color_reg, out_y_reg, out_x_reg});
    assign m_tuser  = out_pv_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== hw/rtl/blcr_setup.sv =====
// Line setup: direction, mode, step count and Bresenham terms from two endpoints.
module blcr_setup
    import blcr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int DW = COORD_BITS + 3
)
(
    input  logic signed [COORD_BITS-1:0] x_start,
    input  logic signed [COORD_BITS-1:0] y_start,
    input  logic signed [COORD_BITS-1:0] x_end,
    input  logic signed [COORD_BITS-1:0] y_end,
    output line_ctrl_t                   ctrl,
    output logic signed [COORD_BITS-1:0] first_x,
    output logic signed [COORD_BITS-1:0] first_y,
    output logic signed [DW-1:0]         decision,
    output logic signed [DW-1:0]         inc_straight,
    output logic signed [DW-1:0]         inc_diagonal,
    output logic        [COORD_BITS-1:0] steps
);

    logic signed [DW-1:0]         ex1, ey1, ex2, ey2;
    logic signed [DW-1:0]         dxs, dys, dxa, dya;
    logic        [COORD_BITS-1:0] dx, dy, dmaj, dmin;
    logic signed [DW-1:0]         dmaj2, dmin2;
    logic                         x_eq, y_eq, x_neg, y_neg, major_x;

    always_comb
    begin
        ex1 = DW'(x_start);
        ey1 = DW'(y_start);
        ex2 = DW'(x_end);
        ey2 = DW'(y_end);
        dxs = ex2 - ex1;
        dys = ey2 - ey1;
        dxa = dxs[DW-1] ? -dxs : dxs;
        dya = dys[DW-1] ? -dys : dys;
        dx  = dxa[COORD_BITS-1:0];
        dy  = dya[COORD_BITS-1:0];
        x_eq  = (x_end == x_start);
        y_eq  = (y_end == y_start);
        x_neg = (x_end < x_start);
        y_neg = (y_end < y_start);
        major_x = (dx >= dy);
        dmaj  = major_x ? dx : dy;
        dmin  = major_x ? dy : dx;
        dmaj2 = DW'({dmaj, 1'b0});
        dmin2 = DW'({dmin, 1'b0});

        ctrl.active     = 1'b1;
        ctrl.x_neg      = x_neg;
        ctrl.y_neg      = y_neg;
        first_x         = x_start;
        first_y         = y_start;
        decision        = '0;
        inc_straight    = '0;
        inc_diagonal    = '0;
        if (x_eq)
        begin
            // run upward from the lower endpoint
            ctrl.mode       = MODE_VERTICAL;
            ctrl.major_is_x = 1'b0;
            ctrl.y_neg      = 1'b0;
            first_y         = y_neg ? y_end : y_start;
            steps           = dy;
        end
        else if (y_eq)
        begin
            ctrl.mode       = MODE_HORIZONTAL;
            ctrl.major_is_x = 1'b1;
            steps           = dx;
        end
        else
        begin
            ctrl.mode       = MODE_BRESENHAM;
            ctrl.major_is_x = major_x;
            decision        = dmin2 - DW'(dmaj);
            inc_straight    = dmin2;
            inc_diagonal    = dmin2 - dmaj2;
            steps           = dmaj;
        end
    end

endmodule

// ===== hw/rtl/blcr_step.sv =====
// Line advance: next point, decision term and remaining count for one step.
module blcr_step
    import blcr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int DW = COORD_BITS + 3
)
(
    input  line_ctrl_t                   ctrl,
    input  logic signed [COORD_BITS-1:0] cur_x,
    input  logic signed [COORD_BITS-1:0] cur_y,
    input  logic signed [DW-1:0]         decision,
    input  logic signed [DW-1:0]         inc_straight,
    input  logic signed [DW-1:0]         inc_diagonal,
    input  logic        [COORD_BITS-1:0] steps,
    output logic signed [COORD_BITS-1:0] next_x,
    output logic signed [COORD_BITS-1:0] next_y,
    output logic signed [DW-1:0]         next_decision,
    output logic        [COORD_BITS-1:0] next_steps
);

    logic signed [COORD_BITS-1:0] stepped_x, stepped_y;
    logic                         diag, move_x, move_y;

    always_comb
    begin
        stepped_x = ctrl.x_neg ? cur_x - COORD_BITS'(1) : cur_x + COORD_BITS'(1);
        stepped_y = ctrl.y_neg ? cur_y - COORD_BITS'(1) : cur_y + COORD_BITS'(1);
        diag      = (decision > 0);
        next_decision = decision;
        move_x = 1'b0;
        move_y = 1'b0;
        unique case (ctrl.mode)
            MODE_VERTICAL:   move_y = 1'b1;
            MODE_HORIZONTAL: move_x = 1'b1;
            MODE_BRESENHAM:
            begin
                next_decision = decision + (diag ? inc_diagonal : inc_straight);
                move_x = ctrl.major_is_x | diag;
                move_y = !ctrl.major_is_x | diag;
            end
            default: ;
        endcase
        next_x     = move_x ? stepped_x : cur_x;
        next_y     = move_y ? stepped_y : cur_y;
        next_steps = steps - COORD_BITS'(1);
    end

endmodule
